/* design/fmga_pkg.sv */
// Package for the FIFO-ordered mutex grant arbiter.
// Shared types and codes; used by fmga_queue_ram and fifo_mutex_grant_arbiter.
`default_nettype none

package fmga_pkg;

   localparam int LANE_W = 2;
   localparam int ID_W = 10;
   localparam int COUNT_W = 7;
   localparam int RELEASE_W = 16;
   localparam logic [RELEASE_W-1:0] RELEASE_MAX = '1;

   typedef enum logic [1:0] {
      CMD_REQUEST = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_LANE_DONE = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      EV_QUEUED = 3'd0,
      EV_GRANTED = 3'd1,
      EV_REJECTED = 3'd2,
      EV_IGNORED = 3'd3,
      EV_LANE_DONE = 3'd4
   } event_type;

   typedef enum logic {
      S_IDLE,
      S_POP
   } state_type;

   // One waiting requester.
   typedef struct packed {
      logic [LANE_W-1:0] lane;
      logic [ID_W-1:0] vehicle_id;
   } entry_type;

   // Queue operations issued by the control logic for one cycle.
   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

endpackage

`default_nettype wire

/* design/fifo_mutex_grant_arbiter.sv */
// Top level of the FIFO-ordered mutex grant arbiter: command decode, grant state, result register.
// Depends on fmga_pkg and fmga_queue_ram.
`default_nettype none

// Grants one shared resource in strict arrival order. Each accepted command word
// yields exactly one result word. Requests, lane-finished commands, idle releases
// and releases with an empty queue are answered from the idle state; a release
// that hands the resource to the head of the waiting queue goes through the pop
// state, since the queue RAM returns the head entry in the cycle after the read.
// A full queue rejects the request with an error result. The queue RAM needs no
// clearing pass after reset: only written entries are ever read. A new command is
// taken in the idle state while the result register is empty or being drained.
module fifo_mutex_grant_arbiter
   import fmga_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64,
   parameter int LANE_COUNT = 4
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [1:0] req_cmd,
   input wire logic [1:0] req_lane,
   input wire logic [9:0] req_vehicle_id,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [2:0] rsp_event_res,
   output logic [1:0] rsp_grant_lane,
   output logic [9:0] rsp_grant_id,
   output logic rsp_from_queue,
   output logic [6:0] rsp_queue_count,
   output logic [15:0] rsp_completed_count,
   output logic rsp_all_done
);

   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int LCMP_W = $clog2(LANE_COUNT + 1) + 1;

   state_type state_ff, state_in;
   logic busy_ff, busy_in;
   logic [RELEASE_W-1:0] release_ff, release_in;
   logic [LANE_COUNT-1:0] mask_ff, mask_in;

   logic rsp_valid_ff, rsp_valid_in;
   event_type event_ff, event_in;
   entry_type grant_ff, grant_in;
   logic from_queue_ff, from_queue_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic all_done_ff, all_done_in;

   queue_ctrl_type qctrl;
   entry_type req_entry;
   entry_type pop_entry;
   logic [FILL_W-1:0] fill;
   logic [FILL_W-1:0] fill_after;
   logic accept;
   logic load_rsp;
   logic lane_ok;
   logic [LANE_COUNT-1:0] lane_bit;

   fmga_queue_ram #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .ctrl(qctrl),
      .push_entry(req_entry),
      .pop_entry(pop_entry),
      .fill(fill)
   );

   assign req_entry = '{lane: req_lane, vehicle_id: req_vehicle_id};
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept = req_valid && req_ready;
   assign lane_ok = LCMP_W'(req_lane) < LCMP_W'(LANE_COUNT);
   assign lane_bit = LANE_COUNT'(1) << req_lane;

   always_comb begin
      state_in = state_ff;
      busy_in = busy_ff;
      release_in = release_ff;
      mask_in = mask_ff;
      qctrl = '{push: 1'b0, pop: 1'b0};
      load_rsp = 1'b0;
      event_in = EV_IGNORED;
      grant_in = '0;
      from_queue_in = 1'b0;
      fill_after = fill;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               load_rsp = 1'b1;
               case (cmd_type'(req_cmd))
                  CMD_REQUEST: begin
                     if (!busy_ff && fill == '0) begin
                        busy_in = 1'b1;
                        event_in = EV_GRANTED;
                        grant_in = req_entry;
                     end else if (fill == FILL_W'(QUEUE_DEPTH)) begin
                        event_in = EV_REJECTED;
                     end else begin
                        qctrl.push = 1'b1;
                        fill_after = fill + 1'b1;
                        event_in = EV_QUEUED;
                     end
                  end
                  CMD_RELEASE: begin
                     if (busy_ff) begin
                        if (release_ff != RELEASE_MAX) begin
                           release_in = release_ff + 1'b1;
                        end
                        if (fill != '0) begin
                           // head entry comes back from the RAM next cycle
                           qctrl.pop = 1'b1;
                           load_rsp = 1'b0;
                           state_in = S_POP;
                        end else begin
                           busy_in = 1'b0;
                        end
                     end
                  end
                  CMD_LANE_DONE: begin
                     if (lane_ok) begin
                        mask_in = mask_ff | lane_bit;
                        event_in = EV_LANE_DONE;
                     end
                  end
                  default: begin
                     event_in = EV_IGNORED;
                  end
               endcase
            end
         end
         S_POP: begin
            // fill and release count already hold their post-step values
            load_rsp = 1'b1;
            event_in = EV_GRANTED;
            grant_in = pop_entry;
            from_queue_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      count_in = COUNT_W'(fill_after);
      all_done_in = (&mask_in) && !busy_in && (fill_after == '0);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff <= 1'b0;
         release_ff <= '0;
         mask_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff <= busy_in;
         release_ff <= release_in;
         mask_ff <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         event_ff <= event_in;
         grant_ff <= grant_in;
         from_queue_ff <= from_queue_in;
         count_ff <= count_in;
         all_done_ff <= all_done_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_event_res = event_ff;
   assign rsp_grant_lane = grant_ff.lane;
   assign rsp_grant_id = grant_ff.vehicle_id;
   assign rsp_from_queue = from_queue_ff;
   assign rsp_queue_count = count_ff;
   assign rsp_completed_count = release_ff;
   assign rsp_all_done = all_done_ff;

endmodule

`default_nettype wire

/* design/fmga_queue_ram.sv */
// Ring queue of waiting requesters: one synchronous RAM plus head and fill pointers.
// Depends on fmga_pkg for entry_type and queue_ctrl_type.
`default_nettype none

module fmga_queue_ram
   import fmga_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input wire logic clock,
   input wire logic reset,
   input wire queue_ctrl_type ctrl,
   input wire entry_type push_entry,
   output entry_type pop_entry,
   output logic [$clog2(DEPTH+1)-1:0] fill
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [PTR_W:0] tail_sum;
   logic [PTR_W-1:0] tail;

   // head + fill stays below twice the depth, so one subtract wraps it
   always_comb begin
      tail_sum = {1'b0, head_ff} + (PTR_W+1)'(fill_ff);
      if (tail_sum >= (PTR_W+1)'(DEPTH)) begin
         tail_sum = tail_sum - (PTR_W+1)'(DEPTH);
      end
      tail = tail_sum[PTR_W-1:0];
   end

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (ctrl.pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
         fill_in = fill_ff - 1'b1;
      end else if (ctrl.push) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail] <= push_entry;
      end
      if (ctrl.pop) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   assign pop_entry = rd_data_ff;
   assign fill = fill_ff;

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking bench for fifo_mutex_grant_arbiter: drives command words, predicts
// every result word in a small scoreboard class and compares them on the fly.
// Depends on fmga_pkg and the design sources only.
module tb_top;
   import fmga_pkg::*;

   localparam int QUEUE_DEPTH = 64;
   localparam int LANE_COUNT = 4;
   localparam int ITEM_TARGET = 2000;
   localparam int TAIL_WORDS = 300;

   typedef struct {
      event_type ev;
      logic [LANE_W-1:0] lane;
      logic [ID_W-1:0] id;
      logic from_queue;
      logic [COUNT_W-1:0] fill;
      logic [RELEASE_W-1:0] releases;
      logic all_done;
   } grant_result_type;

   // Mirror of the arbiter: waiting line, holder flag, lane marks, release count.
   class grant_scoreboard;
      entry_type waiting[$];
      bit busy;
      logic [LANE_COUNT-1:0] lanes_finished;
      int lanes_finished_total;
      logic [RELEASE_W-1:0] releases;
      grant_result_type results_due[$];
      int errors;

      function new();
         busy = 1'b0;
         lanes_finished = '0;
         lanes_finished_total = 0;
         releases = '0;
         errors = 0;
      endfunction

      function void note_word(cmd_type cmd, logic [LANE_W-1:0] lane, logic [ID_W-1:0] id);
         grant_result_type r;
         entry_type e;
         r.ev = EV_IGNORED;
         r.lane = '0;
         r.id = '0;
         r.from_queue = 1'b0;
         e.lane = lane;
         e.vehicle_id = id;
         case (cmd)
            CMD_REQUEST: begin
               if (!busy && waiting.size() == 0) begin
                  busy = 1'b1;
                  r.ev = EV_GRANTED;
                  r.lane = lane;
                  r.id = id;
               end else if (waiting.size() >= QUEUE_DEPTH) begin
                  r.ev = EV_REJECTED;
               end else begin
                  waiting.push_back(e);
                  r.ev = EV_QUEUED;
               end
            end
            CMD_RELEASE: begin
               // release while idle changes no state and answers with an ignored result
               if (busy) begin
                  busy = 1'b0;
                  if (releases != RELEASE_MAX) releases++;
                  if (waiting.size() != 0) begin
                     e = waiting.pop_front();
                     busy = 1'b1;
                     r.ev = EV_GRANTED;
                     r.lane = e.lane;
                     r.id = e.vehicle_id;
                     r.from_queue = 1'b1;
                  end
               end
            end
            CMD_LANE_DONE: begin
               if (lane < LANE_COUNT) begin
                  if (!lanes_finished[lane]) begin
                     lanes_finished[lane] = 1'b1;
                     lanes_finished_total++;
                  end
                  r.ev = EV_LANE_DONE;
               end
            end
            default: ;
         endcase
         r.fill = COUNT_W'(waiting.size());
         r.releases = releases;
         r.all_done = lanes_finished_total >= LANE_COUNT && !busy && waiting.size() == 0;
         results_due.push_back(r);
      endfunction

      function void check_word(logic [2:0] ev, logic [LANE_W-1:0] lane, logic [ID_W-1:0] id,
                               logic from_queue, logic [COUNT_W-1:0] fill,
                               logic [RELEASE_W-1:0] rel, logic all_done);
         grant_result_type r;
         if (results_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: result word with nothing pending, ev=%0d", $time, ev);
            return;
         end
         r = results_due.pop_front();
         if (ev !== r.ev || lane !== r.lane || id !== r.id || from_queue !== r.from_queue ||
             fill !== r.fill || rel !== r.releases || all_done !== r.all_done) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: result mismatch", $time);
               $display("   exp ev=%0d ln=%0d id=%0d fq=%0d n=%0d rel=%0d done=%0d",
                        r.ev, r.lane, r.id, r.from_queue, r.fill, r.releases, r.all_done);
               $display("   got ev=%0d ln=%0d id=%0d fq=%0d n=%0d rel=%0d done=%0d",
                        ev, lane, id, from_queue, fill, rel, all_done);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_cmd;
   logic [1:0] req_lane;
   logic [9:0] req_vehicle_id;
   logic rsp_valid;
   logic rsp_ready;
   logic [2:0] rsp_event_res;
   logic [1:0] rsp_grant_lane;
   logic [9:0] rsp_grant_id;
   logic rsp_from_queue;
   logic [6:0] rsp_queue_count;
   logic [15:0] rsp_completed_count;
   logic rsp_all_done;

   grant_scoreboard sb = new();
   bit quiet = 1'b0;      // no idling on either side
   bit hold_ask = 1'b0;   // asks the response side for one long stall
   int items_sent = 0;

   fifo_mutex_grant_arbiter #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .LANE_COUNT(LANE_COUNT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_lane(req_lane),
      .req_vehicle_id(req_vehicle_id),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_event_res(rsp_event_res),
      .rsp_grant_lane(rsp_grant_lane),
      .rsp_grant_id(rsp_grant_id),
      .rsp_from_queue(rsp_from_queue),
      .rsp_queue_count(rsp_queue_count),
      .rsp_completed_count(rsp_completed_count),
      .rsp_all_done(rsp_all_done)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin : watchdog
      #12_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_word(cmd_type cmd, logic [1:0] lane, logic [9:0] id);
      while (!quiet && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_lane <= lane;
      req_vehicle_id <= id;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(cmd, lane, id);
      items_sent++;
   endtask

   task automatic drain_line();
      while (sb.busy || sb.waiting.size() != 0)
         send_word(CMD_RELEASE, 2'($urandom), 10'($urandom));
   endtask

   // Requests and releases in a given mix, with a little lane-finish and unused noise.
   task automatic mixed_run(int n, int req_pct);
      int k;
      int pick;
      for (k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         if (pick < 5)
            send_word(cmd_type'($urandom_range(1) ? CMD_LANE_DONE : CMD_UNUSED),
                      2'($urandom), 10'($urandom));
         else if (pick < 5 + req_pct * 95 / 100)
            send_word(CMD_REQUEST, 2'($urandom), 10'($urandom));
         else
            send_word(CMD_RELEASE, 2'($urandom), 10'($urandom));
      end
   endtask

   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_word(rsp_event_res, rsp_grant_lane, rsp_grant_id, rsp_from_queue,
                          rsp_queue_count, rsp_completed_count, rsp_all_done);
         if (hold_ask) begin
            hold_ask = 1'b0;
            hold_left = 400;
         end
         if (reset || hold_left > 0) begin
            rsp_ready <= 1'b0;
            if (hold_left > 0) hold_left--;
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= 23);
         end
      end
   end

   initial begin : req_side
      int mode;
      int n;
      bit pressure_done;
      pressure_done = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= CMD_REQUEST;
      req_lane <= '0;
      req_vehicle_id <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: idle release, unused code, direct grant, handover from the line,
      // release with empty line, repeated lane finish, all lanes finished
      send_word(CMD_RELEASE, 2'd3, 10'd1023);
      send_word(CMD_UNUSED, 2'd2, 10'h2AA);
      send_word(CMD_REQUEST, 2'd0, 10'd0);
      send_word(CMD_REQUEST, 2'd3, 10'd1023);
      send_word(CMD_REQUEST, 2'd1, 10'h155);
      send_word(CMD_LANE_DONE, 2'd1, 10'd0);
      send_word(CMD_RELEASE, 2'd0, 10'd0);
      send_word(CMD_LANE_DONE, 2'd1, 10'd1023);
      send_word(CMD_RELEASE, 2'd3, 10'd1023);
      send_word(CMD_RELEASE, 2'd1, 10'h155);
      send_word(CMD_RELEASE, 2'd2, 10'h2AA);
      send_word(CMD_LANE_DONE, 2'd0, 10'd5);
      send_word(CMD_LANE_DONE, 2'd2, 10'd9);
      send_word(CMD_LANE_DONE, 2'd3, 10'd1023);
      send_word(CMD_REQUEST, 2'd2, 10'd512);
      send_word(CMD_UNUSED, 2'd1, 10'h155);
      send_word(CMD_RELEASE, 2'd2, 10'd512);
      send_word(CMD_LANE_DONE, 2'd3, 10'd7);

      while (items_sent < ITEM_TARGET - TAIL_WORDS - 100) begin
         if (!pressure_done && items_sent > ITEM_TARGET / 2) begin
            pressure_done = 1'b1;
            hold_ask = 1'b1;
            mixed_run(60, 50);
         end
         mode = $urandom_range(9);
         case (mode)
            0, 1: begin
               // fill the line to the top, hit the reject path, maybe empty it again
               while (sb.waiting.size() < QUEUE_DEPTH)
                  send_word(CMD_REQUEST, 2'($urandom), 10'($urandom));
               repeat ($urandom_range(1, 3))
                  send_word(CMD_REQUEST, 2'($urandom), 10'($urandom));
               if ($urandom_range(1)) drain_line();
            end
            2: begin
               drain_line();
               send_word(CMD_RELEASE, 2'($urandom), 10'($urandom));
            end
            default: mixed_run($urandom_range(10, 60), $urandom_range(25, 75));
         endcase
      end

      // long run with no idling on either side
      drain_line();
      quiet = 1'b1;
      mixed_run(TAIL_WORDS, 50);
      quiet = 1'b0;
      drain_line();

      req_valid <= 1'b0;
      for (n = 0; n < 10000 && sb.results_due.size() != 0; n++) @(posedge clock);
      repeat (16) @(posedge clock);
      if (sb.errors == 0 && sb.results_due.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
